// ===== sv/ntpf_pkg.sv =====
// ----------------------------------------------------------------------------
// ntpf_pkg
// Shared types, constants and control structs of the clock sample filter.
// ----------------------------------------------------------------------------
package ntpf_pkg;

   localparam int RING_DEPTH_DEFAULT = 8;
   localparam int CSR_ADDR_W = 3;

   localparam logic [29:0] NS_PER_SEC   = 30'd1000000000;
   localparam logic [63:0] RHO          = 64'd4294967;
   localparam logic [63:0] MAX_DISP     = 64'h0000_0010_0000_0000;
   localparam logic [63:0] EPOCH_NS     = 64'd2208988800000000000;
   // Last partial product step of the divider.
   localparam logic [1:0]  DIV_STEPS    = 2'd3;
   // Rounded-up 2^75 / 1953125; one second in ns is 1953125 shifted left 9.
   localparam logic [54:0] DIV_MAGIC    = 55'h44B82FA09B5A53;

   localparam logic CSR_IDX_EPOCH = 1'b0;

   typedef struct packed {
      logic        kind;
      logic [62:0] local_send_ns;
      logic [63:0] remote_rx_stamp;
      logic [63:0] remote_tx_stamp;
      logic [62:0] local_recv_ns;
   } req_type;

   typedef struct packed {
      logic signed [63:0] clock_offset;
      logic signed [63:0] worst_delay;
      logic        [63:0] total_dispersion;
      logic signed [63:0] offset_change;
   } rsp_type;

   typedef enum logic [1:0] {
      MUL_RX_SEC  = 2'd0,
      MUL_RX_FRAC = 2'd1,
      MUL_TX_SEC  = 2'd2,
      MUL_TX_FRAC = 2'd3
   } mul_sel_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_FILL,
      ST_MUL,
      ST_ENTRY_START,
      ST_ENTRY_WAIT,
      ST_SCAN_START,
      ST_SCAN_WAIT,
      ST_OUT
   } state_type;

   typedef struct packed {
      logic        load_req;
      logic        fill_entry;
      logic        mul_issue;
      mul_sel_type mul_issue_sel;
      logic        mul_store;
      mul_sel_type mul_store_sel;
      logic        entry_div_start;
      logic        write_entry;
      logic        scan_div_start;
      logic        scan_acc;
      logic        load_out;
   } cmd_type;

   typedef struct packed {
      logic kind;
      logic div_done;
   } status_type;

endpackage

// ===== sv/ntp_clock_sample_filter.sv =====
// ----------------------------------------------------------------------------
// ntp_clock_sample_filter
// Clock filter over a ring of timing exchange samples.
// ----------------------------------------------------------------------------
// Each transfer on the req_ channel carries one item. An init item (kind 0)
// stamps every ring entry with local_recv_ns, restores the maximum delay and
// dispersion and produces no result.
// A timing exchange (kind 1) converts both remote stamps to ns on a shared
// 32 by 30 multiplier, writes the next ring slot and then scans the ring,
// producing one transfer on the rsp_ channel.
// The aging terms need a division by one second, done by a reciprocal
// multiplication; there is one division for the new entry and one per ring
// entry. One item is in work at a time.
// The result sits in an output register; a stalled receiver holds it there
// while the next item is already accepted, and only the final load waits.
// Reset clears the ring to its idle contents and sets epoch_is_ntp.
// The CSR port holds one register, epoch_is_ntp, at byte address 0.
// ----------------------------------------------------------------------------
module ntp_clock_sample_filter #(
   parameter int RING_DEPTH = ntpf_pkg::RING_DEPTH_DEFAULT
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   output logic                              req_ready,
   input  ntpf_pkg::req_type                 req_data,
   output logic                              rsp_valid,
   input  logic                              rsp_ready,
   output ntpf_pkg::rsp_type                 rsp_data,
   input  logic                              psel,
   input  logic                              penable,
   input  logic                              pwrite,
   input  logic [ntpf_pkg::CSR_ADDR_W-1:0]   paddr,
   input  logic [31:0]                       pwdata,
   output logic [31:0]                       prdata,
   output logic                              pready
);

   localparam int IDX_W = $clog2(RING_DEPTH);

   ntpf_pkg::cmd_type    cmd;
   ntpf_pkg::status_type status;
   logic [IDX_W-1:0]     idx;
   logic                 epoch_ff;

   // The register index is the word address; other addresses are ignored.
   always_ff @(posedge clock) begin
      if (reset) begin
         epoch_ff <= 1'b1;
      end else if (psel && penable && pwrite && paddr[2] == ntpf_pkg::CSR_IDX_EPOCH) begin
         epoch_ff <= pwdata[0];
      end
   end

   assign pready = 1'b1;
   assign prdata = (paddr[2] == ntpf_pkg::CSR_IDX_EPOCH) ? {31'b0, epoch_ff} : 32'b0;

   ntpf_ctrl #(.RING_DEPTH(RING_DEPTH)) u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .status    (status),
      .cmd       (cmd),
      .idx       (idx)
   );

   ntpf_datapath #(.RING_DEPTH(RING_DEPTH)) u_dp (
      .clock        (clock),
      .reset        (reset),
      .epoch_is_ntp (epoch_ff),
      .req_data     (req_data),
      .cmd          (cmd),
      .idx          (idx),
      .status       (status),
      .rsp_data     (rsp_data)
   );

endmodule

// ===== sv/ntpf_divider.sv =====
// ----------------------------------------------------------------------------
// ntpf_divider
// Division of a 64-bit value by one second in ns by reciprocal multiplication,
// one 32 by 32 partial product a cycle.
// ----------------------------------------------------------------------------
module ntpf_divider (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   input  logic [63:0] dividend,
   output logic [63:0] quotient,
   output logic        done
);

   localparam logic [31:0] MAGIC_LO = ntpf_pkg::DIV_MAGIC[31:0];
   localparam logic [31:0] MAGIC_HI = {9'b0, ntpf_pkg::DIV_MAGIC[54:32]};

   logic [54:0]  num_ff, num_in;
   logic [111:0] acc_ff, acc_in;
   logic [1:0]   cnt_ff, cnt_in;
   logic         busy_ff, busy_in;
   logic         done_ff, done_in;
   logic [31:0]  mul_a, mul_b;
   logic [63:0]  part;
   logic [111:0] part_ext;

   // The low nine bits of the dividend drop out, since one second in ns is
   // 1953125 times 512; the rest is multiplied by the rounded-up reciprocal.
   assign mul_a = cnt_ff[1] ? {9'b0, num_ff[54:32]} : num_ff[31:0];
   assign mul_b = cnt_ff[0] ? MAGIC_HI : MAGIC_LO;
   assign part  = mul_a * mul_b;

   always_comb begin
      unique case (cnt_ff)
         2'd0:       part_ext = {48'b0, part};
         2'd1, 2'd2: part_ext = {16'b0, part, 32'b0};
         2'd3:       part_ext = {part[47:0], 64'b0};
         default:    part_ext = '0;
      endcase
   end

   always_comb begin
      num_in  = num_ff;
      acc_in  = acc_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      if (start) begin
         num_in  = dividend[63:9];
         acc_in  = '0;
         cnt_in  = '0;
         busy_in = 1'b1;
      end else if (busy_ff) begin
         acc_in = acc_ff + part_ext;
         cnt_in = cnt_ff + 2'd1;
         if (cnt_ff == ntpf_pkg::DIV_STEPS) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      num_ff <= num_in;
      acc_ff <= acc_in;
      if (reset) begin
         cnt_ff  <= '0;
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         cnt_ff  <= cnt_in;
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   assign quotient = {29'b0, acc_ff[109:75]};
   assign done     = done_ff;

endmodule

// ===== sv/ntpf_datapath.sv =====
// ----------------------------------------------------------------------------
// ntpf_datapath
// Stamp conversion, sample ring, divider and the ring scan accumulators.
// ----------------------------------------------------------------------------
module ntpf_datapath #(
   parameter int RING_DEPTH = ntpf_pkg::RING_DEPTH_DEFAULT,
   localparam int IDX_W = $clog2(RING_DEPTH)
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                epoch_is_ntp,
   input  ntpf_pkg::req_type   req_data,
   input  ntpf_pkg::cmd_type   cmd,
   input  logic [IDX_W-1:0]    idx,
   output ntpf_pkg::status_type status,
   output ntpf_pkg::rsp_type   rsp_data
);

   localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(RING_DEPTH - 1);

   ntpf_pkg::req_type req_ff;
   ntpf_pkg::rsp_type out_ff;
   logic [63:0] time_ff [RING_DEPTH];
   logic [63:0] disp_ff [RING_DEPTH];
   logic [63:0] del_ff  [RING_DEPTH];
   logic [63:0] off_ff  [RING_DEPTH];
   logic [IDX_W-1:0] slot_ff, slot_in;
   logic [63:0] last_off_ff;
   logic [63:0] t1_ff, t2_ff;
   logic [61:0] prod_ff;
   logic [63:0] best_off_ff, best_del_ff, worst_ff, sum_ff;

   logic [31:0] mul_a;
   logic [63:0] t0, t3, conv_sec, conv_acc;
   logic [63:0] dt, div_x, div_dividend, quotient;
   logic [63:0] off_sum, off_half, delay_new;
   logic [63:0] cur_del, aged, aged_shift;
   logic [IDX_W:0] shamt;
   logic        div_done;

   assign t0 = {1'b0, req_ff.local_send_ns};
   assign t3 = {1'b0, req_ff.local_recv_ns};

   always_comb begin
      unique case (cmd.mul_issue_sel)
         ntpf_pkg::MUL_RX_SEC:  mul_a = req_ff.remote_rx_stamp[63:32];
         ntpf_pkg::MUL_RX_FRAC: mul_a = req_ff.remote_rx_stamp[31:0];
         ntpf_pkg::MUL_TX_SEC:  mul_a = req_ff.remote_tx_stamp[63:32];
         ntpf_pkg::MUL_TX_FRAC: mul_a = req_ff.remote_tx_stamp[31:0];
         default:               mul_a = '0;
      endcase
   end

   // Seconds times one second in ns, less the epoch gap already in ns when the NTP epoch is selected.
   assign conv_sec = {2'b0, prod_ff} - (epoch_is_ntp ? ntpf_pkg::EPOCH_NS : 64'd0);
   assign conv_acc = {34'b0, prod_ff[61:32]};

   assign dt    = t3 - t0;
   assign div_x = cmd.scan_div_start ? (t3 - time_ff[idx]) : dt;
   assign div_dividend = {div_x[59:0], 4'b0} - div_x;

   ntpf_divider u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (cmd.entry_div_start | cmd.scan_div_start),
      .dividend (div_dividend),
      .quotient (quotient),
      .done     (div_done)
   );

   assign off_sum   = (t1_ff - t0) + (t2_ff - t3);
   assign off_half  = off_sum[63] ? (64'd0 - ((64'd0 - off_sum) >> 1)) : (off_sum >> 1);
   assign delay_new = dt - (t2_ff - t1_ff);
   assign slot_in   = (slot_ff == LAST_IDX) ? '0 : slot_ff + IDX_W'(1);

   assign cur_del    = del_ff[idx];
   assign aged       = disp_ff[idx] + quotient;
   assign shamt      = {1'b0, idx} + (IDX_W+1)'(1);
   assign aged_shift = aged >> shamt;

   always_ff @(posedge clock) begin
      if (cmd.load_req) begin
         req_ff <= req_data;
      end
      if (cmd.mul_issue) begin
         prod_ff <= 62'(mul_a * ntpf_pkg::NS_PER_SEC);
      end
      if (cmd.mul_store) begin
         unique case (cmd.mul_store_sel)
            ntpf_pkg::MUL_RX_SEC:  t1_ff <= conv_sec;
            ntpf_pkg::MUL_RX_FRAC: t1_ff <= t1_ff + conv_acc;
            ntpf_pkg::MUL_TX_SEC:  t2_ff <= conv_sec;
            ntpf_pkg::MUL_TX_FRAC: t2_ff <= t2_ff + conv_acc;
            default: ;
         endcase
      end
      if (cmd.scan_acc) begin
         if (idx == '0) begin
            best_del_ff <= cur_del;
            best_off_ff <= off_ff[idx];
            worst_ff    <= cur_del;
            sum_ff      <= aged_shift;
         end else begin
            if ($signed(cur_del) < $signed(best_del_ff)) begin
               best_del_ff <= cur_del;
               best_off_ff <= off_ff[idx];
            end
            if ($signed(worst_ff) < $signed(cur_del)) begin
               worst_ff <= cur_del;
            end
            sum_ff <= sum_ff + aged_shift;
         end
      end
      if (cmd.load_out) begin
         out_ff.clock_offset     <= best_off_ff;
         out_ff.worst_delay      <= worst_ff;
         out_ff.total_dispersion <= sum_ff;
         out_ff.offset_change    <= best_off_ff - last_off_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < RING_DEPTH; i++) begin
            time_ff[i] <= '0;
            disp_ff[i] <= ntpf_pkg::MAX_DISP;
            del_ff[i]  <= ntpf_pkg::MAX_DISP;
            off_ff[i]  <= '0;
         end
         slot_ff     <= '0;
         last_off_ff <= '0;
      end else begin
         if (cmd.fill_entry) begin
            time_ff[idx] <= t3;
            disp_ff[idx] <= ntpf_pkg::MAX_DISP;
            del_ff[idx]  <= ntpf_pkg::MAX_DISP;
            off_ff[idx]  <= '0;
            slot_ff      <= '0;
            last_off_ff  <= '0;
         end
         if (cmd.write_entry) begin
            time_ff[slot_in] <= t3;
            off_ff[slot_in]  <= off_half;
            del_ff[slot_in]  <= delay_new;
            disp_ff[slot_in] <= ntpf_pkg::RHO + ntpf_pkg::RHO + quotient;
            slot_ff          <= slot_in;
         end
         if (cmd.load_out) begin
            last_off_ff <= best_off_ff;
         end
      end
   end

   assign status.kind     = req_ff.kind;
   assign status.div_done = div_done;
   assign rsp_data        = out_ff;

endmodule

// ===== sv/ntpf_ctrl.sv =====
// ----------------------------------------------------------------------------
// ntpf_ctrl
// Sequencer for ring fill, stamp conversion, entry write and ring scan.
// ----------------------------------------------------------------------------
module ntpf_ctrl #(
   parameter int RING_DEPTH = ntpf_pkg::RING_DEPTH_DEFAULT,
   localparam int IDX_W = $clog2(RING_DEPTH)
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_ready,
   output logic                 rsp_valid,
   input  logic                 rsp_ready,
   input  ntpf_pkg::status_type status,
   output ntpf_pkg::cmd_type    cmd,
   output logic [IDX_W-1:0]     idx
);

   localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(RING_DEPTH - 1);
   localparam logic [2:0]       MUL_LAST = 3'd4;

   ntpf_pkg::state_type state_ff, state_in;
   logic [IDX_W-1:0] idx_ff, idx_in;
   logic [2:0]       mcnt_ff, mcnt_in;
   logic             rsp_valid_ff, rsp_valid_in;
   logic             out_free;

   assign out_free = !rsp_valid_ff || rsp_ready;

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ntpf_pkg::ST_IDLE:
            if (req_valid) begin
               state_in = ntpf_pkg::ST_MUL;
            end
         ntpf_pkg::ST_MUL:
            if (!status.kind) begin
               state_in = ntpf_pkg::ST_FILL;
            end else if (mcnt_ff == MUL_LAST) begin
               state_in = ntpf_pkg::ST_ENTRY_START;
            end
         ntpf_pkg::ST_FILL:
            if (idx_ff == LAST_IDX) begin
               state_in = ntpf_pkg::ST_IDLE;
            end
         ntpf_pkg::ST_ENTRY_START: state_in = ntpf_pkg::ST_ENTRY_WAIT;
         ntpf_pkg::ST_ENTRY_WAIT:
            if (status.div_done) begin
               state_in = ntpf_pkg::ST_SCAN_START;
            end
         ntpf_pkg::ST_SCAN_START: state_in = ntpf_pkg::ST_SCAN_WAIT;
         ntpf_pkg::ST_SCAN_WAIT:
            if (status.div_done) begin
               state_in = (idx_ff == LAST_IDX) ? ntpf_pkg::ST_OUT : ntpf_pkg::ST_SCAN_START;
            end
         ntpf_pkg::ST_OUT:
            if (out_free) begin
               state_in = ntpf_pkg::ST_IDLE;
            end
         default: state_in = ntpf_pkg::ST_IDLE;
      endcase
   end

   always_comb begin
      cmd           = '0;
      cmd.mul_issue_sel = ntpf_pkg::mul_sel_type'(mcnt_ff[1:0]);
      cmd.mul_store_sel = ntpf_pkg::mul_sel_type'(2'(mcnt_ff - 3'd1));
      req_ready     = 1'b0;
      unique case (state_ff)
         ntpf_pkg::ST_IDLE: begin
            req_ready    = 1'b1;
            cmd.load_req = req_valid;
         end
         ntpf_pkg::ST_MUL: begin
            cmd.mul_issue = status.kind && (mcnt_ff != MUL_LAST);
            cmd.mul_store = status.kind && (mcnt_ff != 3'd0);
         end
         ntpf_pkg::ST_FILL:        cmd.fill_entry      = 1'b1;
         ntpf_pkg::ST_ENTRY_START: cmd.entry_div_start = 1'b1;
         ntpf_pkg::ST_ENTRY_WAIT:  cmd.write_entry     = status.div_done;
         ntpf_pkg::ST_SCAN_START:  cmd.scan_div_start  = 1'b1;
         ntpf_pkg::ST_SCAN_WAIT:   cmd.scan_acc        = status.div_done;
         ntpf_pkg::ST_OUT:         cmd.load_out        = out_free;
         default: ;
      endcase
   end

   always_comb begin
      idx_in       = idx_ff;
      mcnt_in      = mcnt_ff;
      rsp_valid_in = rsp_valid_ff;
      if (rsp_valid_ff && rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
      if (cmd.load_out) begin
         rsp_valid_in = 1'b1;
      end
      if (state_ff == ntpf_pkg::ST_IDLE) begin
         idx_in  = '0;
         mcnt_in = '0;
      end else if (state_ff == ntpf_pkg::ST_MUL) begin
         mcnt_in = mcnt_ff + 3'd1;
      end else if (state_ff == ntpf_pkg::ST_FILL) begin
         idx_in = idx_ff + IDX_W'(1);
      end else if (cmd.scan_acc) begin
         idx_in = idx_ff + IDX_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ntpf_pkg::ST_IDLE;
         idx_ff       <= '0;
         mcnt_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         idx_ff       <= idx_in;
         mcnt_ff      <= mcnt_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign idx       = idx_ff;
   assign rsp_valid = rsp_valid_ff;

endmodule

// ===== sv/ntpf_checker.sv =====
// ----------------------------------------------------------------------------
// ntpf_checker
// Port-level assertions of the clock sample filter, bound to the top level.
// ----------------------------------------------------------------------------
module ntpf_checker (
   input logic              clock,
   input logic              reset,
   input logic              req_valid,
   input logic              req_ready,
   input ntpf_pkg::req_type req_data,
   input logic              rsp_valid,
   input logic              rsp_ready,
   input ntpf_pkg::rsp_type rsp_data,
   input logic              pready
);

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_data))
      else $error("result changed while stalled");

   a_busy: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("second item taken while one is in work");

   a_init_quiet: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready && !req_data.kind && !rsp_valid |=> !rsp_valid)
      else $error("init item produced a result");

   a_reset_empty: assert property (@(posedge clock)
      $past(reset) |-> !rsp_valid && pready)
      else $error("result pending after reset");

endmodule

bind ntp_clock_sample_filter ntpf_checker u_ntpf_checker (.*);

// ===== bench/ntp_clock_sample_filter_test.sv =====
// ----------------------------------------------------------------------------
// ntp_clock_sample_filter_test
// Self-checking bench for the clock sample filter: directed exchanges, init
// items and epoch settings, then random traffic under bursty send and stall.
// ----------------------------------------------------------------------------
module ntp_clock_sample_filter_test;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int DEPTH = ntpf_pkg::RING_DEPTH_DEFAULT;
   localparam logic [63:0] EPOCH_SEC = 64'd2208988800;
   localparam logic [63:0] SEC_NS = 64'd1000000000;
   localparam logic [63:0] DRIFT = 64'd15;
   localparam logic [ntpf_pkg::CSR_ADDR_W-1:0] ADDR_EPOCH = '0;
   // Wait well past the end of an init item.
   localparam int INIT_SETTLE = 40;
   localparam longint CYCLE_LIMIT = 4000000;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_ready;
   ntpf_pkg::req_type req_data = '0;
   logic rsp_valid;
   logic rsp_ready = 1'b0;
   ntpf_pkg::rsp_type rsp_data;
   logic psel = 1'b0;
   logic penable = 1'b0;
   logic pwrite = 1'b0;
   logic [ntpf_pkg::CSR_ADDR_W-1:0] paddr = '0;
   logic [31:0] pwdata = '0;
   logic [31:0] prdata;
   logic pready;

   ntp_clock_sample_filter u_dut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_ready(req_ready), .req_data(req_data),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready), .rsp_data(rsp_data),
      .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
      .pwdata(pwdata), .prdata(prdata), .pready(pready)
   );

   always #2 clock = ~clock;

   // Shadow of the filter state, updated as each item is sent.
   logic [63:0] ring_time [DEPTH];
   logic [63:0] ring_disp [DEPTH];
   logic [63:0] ring_delay [DEPTH];
   logic [63:0] ring_offset [DEPTH];
   int unsigned ring_slot;
   logic [63:0] prev_offset;
   logic ntp_epoch;

   ntpf_pkg::rsp_type filter_results[$];
   int error_count = 0;
   longint cycle_count = 0;
   int stall_mode = 0;

   task automatic report_mismatch(input string what, input logic [63:0] got,
                                  input logic [63:0] want);
      $display("MISMATCH %s: got %h expected %h at %0t", what, got, want, $realtime);
      error_count++;
   endtask

   function automatic logic [63:0] stamp_ns(input logic [63:0] stamp);
      logic [63:0] secs;
      logic [63:0] frac;
      secs = {32'd0, stamp[63:32]};
      frac = {32'd0, stamp[31:0]};
      if (ntp_epoch) secs = secs - EPOCH_SEC;
      return secs * SEC_NS + ((frac * SEC_NS) >> 32);
   endfunction

   function automatic void clear_ring(input logic [63:0] t);
      for (int i = 0; i < DEPTH; i++) begin
         ring_time[i] = t;
         ring_disp[i] = ntpf_pkg::MAX_DISP;
         ring_delay[i] = ntpf_pkg::MAX_DISP;
         ring_offset[i] = '0;
      end
      ring_slot = 0;
      prev_offset = '0;
   endfunction

   // Apply one item to the shadow state and queue the result it produces.
   function automatic void predict_filter(input ntpf_pkg::req_type item);
      logic [63:0] t0, t1, t2, t3, sum, best_off, worst, disp_sum, aged;
      logic signed [63:0] best_del;
      ntpf_pkg::rsp_type res;
      t0 = {1'b0, item.local_send_ns};
      t3 = {1'b0, item.local_recv_ns};
      if (!item.kind) begin
         clear_ring(t3);
         return;
      end
      t1 = stamp_ns(item.remote_rx_stamp);
      t2 = stamp_ns(item.remote_tx_stamp);
      ring_slot = (ring_slot + 1) % DEPTH;
      ring_time[ring_slot] = t3;
      sum = (t1 - t0) + (t2 - t3);
      // Signed halving rounds toward zero.
      ring_offset[ring_slot] = sum[63] ? (64'd0 - ((64'd0 - sum) >> 1)) : (sum >> 1);
      ring_delay[ring_slot] = (t3 - t0) - (t2 - t1);
      ring_disp[ring_slot] = ntpf_pkg::RHO + ntpf_pkg::RHO + ((t3 - t0) * DRIFT) / SEC_NS;
      best_off = ring_offset[0];
      best_del = ring_delay[0];
      worst = ring_delay[0];
      disp_sum = '0;
      for (int i = 0; i < DEPTH; i++) begin
         if ($signed(ring_delay[i]) < best_del) begin
            best_del = ring_delay[i];
            best_off = ring_offset[i];
         end
         if ($signed(worst) < $signed(ring_delay[i])) worst = ring_delay[i];
         aged = ring_disp[i] + ((t3 - ring_time[i]) * DRIFT) / SEC_NS;
         disp_sum = disp_sum + (aged >> (i + 1));
      end
      res.clock_offset = best_off;
      res.worst_delay = worst;
      res.total_dispersion = disp_sum;
      res.offset_change = best_off - prev_offset;
      prev_offset = best_off;
      filter_results.push_back(res);
   endfunction

   // Cycle counter and timeout.
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("ntp_clock_sample_filter verification failed");
         $finish;
      end
   end

   // Receiver: stalls follow a pattern chosen by the running test.
   always @(posedge clock) begin
      case (stall_mode)
         0: rsp_ready <= 1'b1;
         1: rsp_ready <= ($urandom_range(0, 3) != 0);
         2: rsp_ready <= (cycle_count[5:3] != 3'd5);
         default: rsp_ready <= ($urandom_range(0, 9) == 0);
      endcase
   end

   // Result checker.
   always @(posedge clock) begin
      ntpf_pkg::rsp_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (filter_results.size() == 0) begin
            report_mismatch("unexpected transfer", rsp_data.clock_offset, 64'd0);
         end else begin
            want = filter_results.pop_front();
            if (rsp_data.clock_offset !== want.clock_offset)
               report_mismatch("clock_offset", rsp_data.clock_offset, want.clock_offset);
            if (rsp_data.worst_delay !== want.worst_delay)
               report_mismatch("worst_delay", rsp_data.worst_delay, want.worst_delay);
            if (rsp_data.total_dispersion !== want.total_dispersion)
               report_mismatch("total_dispersion", rsp_data.total_dispersion,
                               want.total_dispersion);
            if (rsp_data.offset_change !== want.offset_change)
               report_mismatch("offset_change", rsp_data.offset_change, want.offset_change);
         end
      end
   end

   // Send one item and hold it until the transfer completes; the block is busy
   // afterwards, so valid rests low for one cycle.
   task automatic send_item(input ntpf_pkg::req_type item);
      req_valid <= 1'b1;
      req_data <= item;
      predict_filter(item);
      do @(posedge clock); while (!req_ready);
      req_valid <= 1'b0;
      @(posedge clock);
   endtask

   task automatic idle_cycles(input int n);
      repeat (n) @(posedge clock);
   endtask

   // Block goes idle: all results in, then room for a trailing init item.
   task automatic drain();
      while (filter_results.size() != 0) @(posedge clock);
      idle_cycles(INIT_SETTLE);
   endtask

   task automatic write_epoch(input logic value);
      psel <= 1'b1; penable <= 1'b0; pwrite <= 1'b1;
      paddr <= ADDR_EPOCH; pwdata <= {31'd0, value};
      @(posedge clock);
      penable <= 1'b1;
      do @(posedge clock); while (!pready);
      psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
      ntp_epoch = value;
      @(posedge clock);
   endtask

   // A plausible exchange: remote clock near local time plus a skew.
   function automatic ntpf_pkg::req_type make_exchange();
      ntpf_pkg::req_type item;
      logic [63:0] base, secs;
      base = {$urandom_range(0, 32'h7fffffff), $urandom()} >> $urandom_range(0, 30);
      item.kind = 1'b1;
      item.local_send_ns = base[62:0];
      item.local_recv_ns = base[62:0] + $urandom_range(0, 50000000);
      secs = base / SEC_NS + (ntp_epoch ? EPOCH_SEC : 64'd0) + $urandom_range(0, 4) - 2;
      item.remote_rx_stamp = {secs[31:0], $urandom()};
      item.remote_tx_stamp = {secs[31:0] + $urandom_range(0, 1), $urandom()};
      return item;
   endfunction

   function automatic ntpf_pkg::req_type make_noise();
      ntpf_pkg::req_type item;
      item.kind = 1'b1;
      item.local_send_ns = 63'({$urandom(), $urandom()});
      item.remote_rx_stamp = {$urandom(), $urandom()};
      item.remote_tx_stamp = {$urandom(), $urandom()};
      item.local_recv_ns = 63'({$urandom(), $urandom()});
      return item;
   endfunction

   // Extremes of every field, init items and a full lap of the ring.
   task automatic test_directed();
      ntpf_pkg::req_type item;
      stall_mode = 0;
      item = '0; item.kind = 1'b1;
      send_item(item);
      item = '1;
      send_item(item);
      item = '0; item.kind = 1'b1; item.local_recv_ns = '1;
      item.remote_tx_stamp = '1;
      send_item(item);
      item = '0; item.local_recv_ns = 63'd123456789;  // init item
      send_item(item);
      for (int i = 0; i < 10; i++) send_item(make_exchange());
      item = '1; item.kind = 1'b0;                     // init at maximum time
      send_item(item);
      item = '0; item.kind = 1'b1; item.local_send_ns = '1;
      send_item(item);
      // Stamps below the epoch wrap when the NTP epoch is selected.
      item = '0; item.kind = 1'b1; item.remote_rx_stamp = 64'h0000_0001_8000_0000;
      item.local_recv_ns = 63'd5;
      send_item(item);
      drain();
   endtask

   task automatic test_epoch_modes();
      write_epoch(1'b0);
      stall_mode = 1;
      for (int i = 0; i < 12; i++) send_item(make_exchange());
      drain();
      write_epoch(1'b1);
      for (int i = 0; i < 12; i++) send_item(make_exchange());
      drain();
   endtask

   // Bursts of random length with gaps; most exchanges plausible.
   task automatic test_random(input int count, input int mode);
      int sent;
      ntpf_pkg::req_type item;
      sent = 0;
      stall_mode = mode;
      while (sent < count) begin
         repeat ($urandom_range(1, 12)) begin
            case ($urandom_range(0, 19))
               0: begin
                  item = make_noise();
                  item.kind = 1'b0;
               end
               1, 2: item = make_noise();
               default: item = make_exchange();
            endcase
            send_item(item);
            sent++;
         end
         idle_cycles($urandom_range(0, 3) == 0 ? 0 : $urandom_range(1, 40));
      end
      drain();
   endtask

   initial begin
      ntp_epoch = 1'b1;
      clear_ring('0);
      idle_cycles(8);
      reset <= 1'b0;
      @(posedge clock);
      test_directed();
      test_epoch_modes();
      test_random(500, 1);
      write_epoch(1'b0);
      test_random(400, 2);
      write_epoch(1'b1);
      test_random(350, 3);
      test_random(400, 0);
      drain();
      if (error_count == 0) begin
         $display("ntp_clock_sample_filter verification clean");
      end else begin
         $display("ntp_clock_sample_filter verification failed");
      end
      $finish;
   end

endmodule
